>>> rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC field splitter package
// Shared constants, result codes and the result record type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrmc_pkg;

  // Capacity of one field and length limit of one sentence.
  localparam logic [4:0] FIELD_CHARS_MAX  = 5'd16;
  localparam logic [6:0] SENTENCE_LEN_MAX = 7'd80;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;

  // Header positions that must hold 'M' and 'C'.
  localparam logic [6:0] POS_M = 7'd4;
  localparam logic [6:0] POS_C = 7'd5;

  // Field numbers.
  localparam logic [2:0] HEADER_FIELD = 3'd0;
  localparam logic [2:0] FIRST_FIELD  = 3'd1;
  localparam logic [2:0] STATUS_FIELD = 3'd2;
  localparam logic [2:0] LAST_FIELD   = 3'd6;

  // Result word kinds.
  localparam logic [1:0] KIND_FIELD_CHAR = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;
  localparam logic [1:0] KIND_MALFORMED  = 2'd3;

  // One result word as produced by the parser.
  typedef struct packed {
    logic       valid;
    logic [1:0] item_kind;
    logic [2:0] field_number;
    logic [4:0] char_index;
    logic [7:0] char_code;
    logic       fix_valid;
    logic       field_truncated;
  } nrmc_result_t;

endpackage

>>> rtl/nmea_rmc_field_splitter_unit.sv
// A character's result word goes from the input register to the result register;
// only a character whose word meets a full output waits in the input register.
// Throughput: one character per cycle while no word meets a full output.
// The result register is the only point of back-pressure from the output side.
// Reset clears the sentence state, the fix flag and both valid flags.
// ----------------------------------------------------------------------------
// NMEA RMC field splitter
// Splits a stream of received characters into the RMC fields time to E/W,
// with field-end, record-complete and malformed-sentence words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_rmc_field_splitter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_char,
  output logic       item_valid,
  input  logic       item_ready,
  output logic [1:0] item_kind,
  output logic [2:0] field_number,
  output logic [4:0] char_index,
  output logic [7:0] char_code,
  output logic       fix_valid,
  output logic       field_truncated
);

  import nrmc_pkg::*;

  logic         hold_valid;
  logic [7:0]   hold_char;
  logic         advance;
  nrmc_result_t step_result;
  nrmc_result_t out_word;

  // Parser core with the sentence state.
  nrmc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_char (hold_char),
    .result  (step_result)
  );

  // A held character moves on unless it makes a word and the output is full.
  assign advance  = hold_valid && (!step_result.valid || !item_valid || item_ready);
  assign rx_ready = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_ready) begin
      hold_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      hold_char <= rx_char;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance && step_result.valid) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_result.valid) begin
      out_word <= step_result;
    end
  end

  assign item_kind       = out_word.item_kind;
  assign field_number    = out_word.field_number;
  assign char_index      = out_word.char_index;
  assign char_code       = out_word.char_code;
  assign fix_valid       = out_word.fix_valid;
  assign field_truncated = out_word.field_truncated;

endmodule

>>> rtl/nrmc_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser core
// Holds the sentence state and works out, for one character, the next state
// and the result word that the character causes, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrmc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_char,
  output nrmc_pkg::nrmc_result_t result
);

  import nrmc_pkg::*;

  logic [6:0] sentence_pos, sentence_pos_next;
  logic [2:0] comma_count, comma_count_next;
  logic [4:0] field_char_count, field_char_count_next;
  logic       in_sentence, in_sentence_next;
  logic [7:0] status_first_char, status_first_char_next;
  logic       fix_flag, fix_flag_next;
  logic       trunc;
  logic [4:0] field_len;

  // Truncation and reported length of the field closed by a comma.
  assign trunc     = (field_char_count > FIELD_CHARS_MAX);
  assign field_len = trunc ? FIELD_CHARS_MAX : field_char_count;

  // Next state and result word for the character at the input.
  always_comb begin
    sentence_pos_next      = sentence_pos;
    comma_count_next       = comma_count;
    field_char_count_next  = field_char_count;
    in_sentence_next       = in_sentence;
    status_first_char_next = status_first_char;
    fix_flag_next          = fix_flag;

    result                 = '0;

    if (rx_char == CH_DOLLAR) begin
      // A dollar always opens a new sentence; an open one is cut short.
      in_sentence_next       = 1'b1;
      sentence_pos_next      = 7'd1;
      comma_count_next       = HEADER_FIELD;
      field_char_count_next  = 5'd0;
      status_first_char_next = 8'd0;
      if (in_sentence) begin
        result.valid        = 1'b1;
        result.item_kind    = KIND_MALFORMED;
        result.field_number = comma_count;
      end
    end else if (in_sentence) begin
      if (sentence_pos >= SENTENCE_LEN_MAX) begin
        // Sentence ran past the length limit.
        in_sentence_next    = 1'b0;
        result.valid        = 1'b1;
        result.item_kind    = KIND_MALFORMED;
        result.field_number = comma_count;
      end else begin
        sentence_pos_next = sentence_pos + 7'd1;
        if ((sentence_pos == POS_M && rx_char != CH_M) ||
            (sentence_pos == POS_C && rx_char != CH_C)) begin
          // Not an RMC sentence: wait for the next dollar.
          in_sentence_next = 1'b0;
        end else if (rx_char == CH_COMMA) begin
          result.valid           = 1'b1;
          result.char_index      = field_len;
          result.field_truncated = trunc;
          if (comma_count >= LAST_FIELD) begin
            in_sentence_next    = 1'b0;
            result.item_kind    = KIND_RECORD_END;
            result.field_number = LAST_FIELD;
          end else begin
            if (comma_count == STATUS_FIELD) begin
              if (status_first_char == CH_A) begin
                fix_flag_next = 1'b1;
              end else if (status_first_char == CH_V) begin
                fix_flag_next = 1'b0;
              end
            end
            comma_count_next      = comma_count + 3'd1;
            field_char_count_next = 5'd0;
            result.item_kind      = KIND_FIELD_END;
            result.field_number   = comma_count;
          end
        end else begin
          // Ordinary field character.
          if (comma_count == STATUS_FIELD && field_char_count == 5'd0) begin
            status_first_char_next = rx_char;
          end
          if (field_char_count < FIELD_CHARS_MAX) begin
            field_char_count_next = field_char_count + 5'd1;
            if (comma_count >= FIRST_FIELD) begin
              result.valid        = 1'b1;
              result.item_kind    = KIND_FIELD_CHAR;
              result.field_number = comma_count;
              result.char_index   = field_char_count;
              result.char_code    = rx_char;
            end
          end else begin
            field_char_count_next = FIELD_CHARS_MAX + 5'd1;
          end
        end
      end
    end

    result.fix_valid = fix_flag_next;
  end

  // Sentence state, updated once for each character that passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_pos      <= '0;
      comma_count       <= '0;
      field_char_count  <= '0;
      in_sentence       <= 1'b0;
      status_first_char <= '0;
      fix_flag          <= 1'b0;
    end else if (step) begin
      sentence_pos      <= sentence_pos_next;
      comma_count       <= comma_count_next;
      field_char_count  <= field_char_count_next;
      in_sentence       <= in_sentence_next;
      status_first_char <= status_first_char_next;
      fix_flag          <= fix_flag_next;
    end
  end

endmodule
